FILE: design/single_precision_float_unit_top_macros.svh
// Assertion helpers shared by the float unit RTL.
`ifndef SINGLE_PRECISION_FLOAT_UNIT_TOP_MACROS_SVH
`define SINGLE_PRECISION_FLOAT_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SPFU_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SPFU_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SPFU_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define SPFU_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: design/spfu_pkg.sv
package spfu_pkg;

	localparam int SPFU_NUM_FREGS = 32;
	localparam int DIV_STEPS      = 26;

	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_LOAD = 3'd4;
	localparam logic [2:0] CMD_MOVE = 3'd5;

	localparam logic [4:0] FL_NV = 5'h10;
	localparam logic [4:0] FL_DZ = 5'h08;
	localparam logic [4:0] FL_OF = 5'h04;
	localparam logic [4:0] FL_UF = 5'h02;
	localparam logic [4:0] FL_NX = 5'h01;

	localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;
	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic [31:0] INF_BITS  = 32'h7f80_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_NORM,
		ST_ALIGN,
		ST_ADD,
		ST_LNORM,
		ST_MUL,
		ST_DIV,
		ST_DFIN,
		ST_DENORM,
		ST_ROUND,
		ST_DONE
	} state_t;

	function automatic logic is_nan(input logic [31:0] x);
		return x[30:0] > INF_BITS[30:0];
	endfunction

	function automatic logic is_snan(input logic [31:0] x);
		return is_nan(x) && !x[22];
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return x[30:0] == INF_BITS[30:0];
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

endpackage

FILE: design/spfu_ifs.sv
interface spfu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [4:0]  dest_index;
	logic [4:0]  src1_index;
	logic [4:0]  src2_index;
	logic [31:0] load_data;

	modport source(output valid, command, dest_index, src1_index, src2_index, load_data,
		input ready);
	modport sink(input valid, command, dest_index, src1_index, src2_index, load_data,
		output ready);
endinterface

interface spfu_rsp_if;
	logic               valid;
	logic               ready;
	logic [31:0]        written_value;
	logic signed [31:0] move_value;
	logic [4:0]         accrued_flags;

	modport source(output valid, written_value, move_value, accrued_flags, input ready);
	modport sink(input valid, written_value, move_value, accrued_flags, output ready);
endinterface

FILE: design/single_precision_float_unit_top.sv
// Channel | Direction | Payload
// req     | in        | command, dest_index, src1_index, src2_index, load_data
// rsp     | out       | written_value, move_value, accrued_flags
//
// Load, move and unused commands, and arithmetic with special operands, go from fetch to done.
// Add and multiply normalize a subnormal operand one bit per step, and add normalizes one
// bit per step after cancellation in an effective subtraction. Divide normalizes subnormal
// operands the same way; the restoring divider produces one quotient bit per cycle
// over 26 steps.
// Reset clears the register file valid bits, the sticky flags and the sequencer; a register
// that was never written reads as zero. A stalled result holds in the output register;
// the next item is accepted meanwhile and waits for it only in the done state.
`include "single_precision_float_unit_top_macros.svh"

module single_precision_float_unit_top #(
	parameter int NUM_FREGS = spfu_pkg::SPFU_NUM_FREGS
) (
	input logic        clk,
	input logic        arst_n,
	spfu_req_if.sink   req,
	spfu_rsp_if.source rsp
);
	import spfu_pkg::*;

	localparam int IW = $clog2(NUM_FREGS);

	// Index reduction modulo the register count by restoring compare and subtract.
	function automatic logic [IW-1:0] reg_sel(input logic [4:0] v);
		logic [10:0] t;
		logic [10:0] lim;
		t = {6'd0, v};
		for (int k = 4; k >= 0; k--) begin
			lim = 11'(NUM_FREGS) << k;
			if (t >= lim) begin
				t = t - lim;
			end
		end
		return t[IW-1:0];
	endfunction

	state_t state_q, state_d;

	// Register file: memory array plus one valid bit per entry so that reset reads zero.
	logic [31:0]          mem_q [NUM_FREGS];
	logic [NUM_FREGS-1:0] vld_q;
	logic [31:0]          rda_q, rdb_q;
	logic                 va_q, vb_q;

	// Item fields captured at acceptance.
	logic [2:0]    cmd_q;
	logic [IW-1:0] rd_q;
	logic [31:0]   ld_q;

	// Working registers of the shared datapath.
	logic [31:0]        res_q, mv_q;
	logic [4:0]         fl_q, sticky_q;
	logic               wr_q, sign_q, esub_q, sub_q, tiny_q;
	logic [23:0]        sa_q, sb_q;
	logic signed [11:0] ea_q, eb_q, e_q;
	logic [63:0]        m_q;
	logic [62:0]        mb_q;
	logic [25:0]        rem_q, qt_q;
	logic [4:0]         cnt_q;

	// Output register.
	logic        ovalid_q;
	logic [31:0] owv_q, omv_q;
	logic [4:0]  ofl_q;

	logic accept, out_free, out_load, mem_we;

	assign accept   = req.valid && req.ready;
	assign out_free = !ovalid_q || rsp.ready;

	assign rsp.valid         = ovalid_q;
	assign rsp.written_value = owv_q;
	assign rsp.move_value    = $signed(omv_q);
	assign rsp.accrued_flags = ofl_q;

	// Operand decode and special cases, evaluated in the fetch state.
	logic [31:0] a_op, b_raw, b_op, x_op, y_op;
	logic        dec_done, dec_wr;
	logic [31:0] dec_res, dec_mv;
	logic [4:0]  dec_fl;
	logic signed [11:0] ux_e, uy_e;
	logic [23:0] ux_s, uy_s;

	always_comb begin
		a_op  = va_q ? rda_q : 32'd0;
		b_raw = vb_q ? rdb_q : 32'd0;
		b_op  = (cmd_q == CMD_SUB) ? (b_raw ^ SIGN_BIT) : b_raw;
		x_op  = a_op;
		y_op  = b_op;
		dec_done = 1'b1;
		dec_wr   = 1'b0;
		dec_res  = 32'd0;
		dec_mv   = 32'd0;
		dec_fl   = 5'd0;
		unique case (cmd_q) inside
			CMD_ADD, CMD_SUB: begin
				dec_wr = 1'b1;
				if (is_nan(a_op) || is_nan(b_op)) begin
					dec_res = CANON_NAN;
					if (is_snan(a_op) || is_snan(b_op)) dec_fl = FL_NV;
				end else if (is_inf(a_op) || is_inf(b_op)) begin
					if (is_inf(a_op) && is_inf(b_op) && (a_op[31] != b_op[31])) begin
						dec_res = CANON_NAN;
						dec_fl  = FL_NV;
					end else begin
						dec_res = is_inf(a_op) ? a_op : b_op;
					end
				end else if (is_zero(a_op) && is_zero(b_op)) begin
					dec_res = {a_op[31] & b_op[31], 31'd0};
				end else if (is_zero(a_op)) begin
					dec_res = b_op;
				end else if (is_zero(b_op)) begin
					dec_res = a_op;
				end else begin
					dec_done = 1'b0;
					if (a_op[30:0] < b_op[30:0]) begin
						x_op = b_op;
						y_op = a_op;
					end
				end
			end
			CMD_MUL: begin
				dec_wr = 1'b1;
				if (is_nan(a_op) || is_nan(b_op)) begin
					dec_res = CANON_NAN;
					if (is_snan(a_op) || is_snan(b_op)) dec_fl = FL_NV;
				end else if (is_inf(a_op) || is_inf(b_op)) begin
					if (is_zero(a_op) || is_zero(b_op)) begin
						dec_res = CANON_NAN;
						dec_fl  = FL_NV;
					end else begin
						dec_res = {a_op[31] ^ b_op[31], INF_BITS[30:0]};
					end
				end else if (is_zero(a_op) || is_zero(b_op)) begin
					dec_res = {a_op[31] ^ b_op[31], 31'd0};
				end else begin
					dec_done = 1'b0;
				end
			end
			CMD_DIV: begin
				dec_wr = 1'b1;
				if (is_nan(a_op) || is_nan(b_op)) begin
					dec_res = CANON_NAN;
					if (is_snan(a_op) || is_snan(b_op)) dec_fl = FL_NV;
				end else if (is_inf(a_op)) begin
					if (is_inf(b_op)) begin
						dec_res = CANON_NAN;
						dec_fl  = FL_NV;
					end else begin
						dec_res = {a_op[31] ^ b_op[31], INF_BITS[30:0]};
					end
				end else if (is_inf(b_op)) begin
					dec_res = {a_op[31] ^ b_op[31], 31'd0};
				end else if (is_zero(b_op)) begin
					if (is_zero(a_op)) begin
						dec_res = CANON_NAN;
						dec_fl  = FL_NV;
					end else begin
						dec_res = {a_op[31] ^ b_op[31], INF_BITS[30:0]};
						dec_fl  = FL_DZ;
					end
				end else if (is_zero(a_op)) begin
					dec_res = {a_op[31] ^ b_op[31], 31'd0};
				end else begin
					dec_done = 1'b0;
				end
			end
			CMD_LOAD: begin
				dec_wr  = 1'b1;
				dec_res = ld_q;
			end
			CMD_MOVE: begin
				dec_mv = a_op;
			end
			default: begin
			end
		endcase

		// Unpack; a subnormal keeps its raw fraction and is normalized over cycles.
		if (x_op[30:23] == 8'd0) begin
			ux_e = -12'sd126;
			ux_s = {1'b0, x_op[22:0]};
		end else begin
			ux_e = $signed({4'd0, x_op[30:23]}) - 12'sd127;
			ux_s = {1'b1, x_op[22:0]};
		end
		if (y_op[30:23] == 8'd0) begin
			uy_e = -12'sd126;
			uy_s = {1'b0, y_op[22:0]};
		end else begin
			uy_e = $signed({4'd0, y_op[30:23]}) - 12'sd127;
			uy_s = {1'b1, y_op[22:0]};
		end
	end

	// Shared arithmetic: align, add, multiply, divide step and rounding terms.
	logic signed [11:0] exp_gap, bexp, dsh;
	logic [62:0]        mb_full, mb_shift, m_shift;
	logic               mb_lost, m_lost;
	logic [63:0]        sum, dif;
	logic [47:0]        prod;
	logic [25:0]        rem_sub;
	logic               q_bit;
	logic [23:0]        rq;
	logic               rbit, sbit, rup, carry0;
	logic [24:0]        q1;
	logic signed [11:0] bb;

	always_comb begin
		exp_gap  = ea_q - eb_q;
		mb_full  = {sb_q, 39'd0};
		mb_shift = mb_full >> exp_gap[5:0];
		mb_lost  = |(mb_full & ~({63{1'b1}} << exp_gap[5:0]));
		sum      = m_q + {1'b0, mb_q};
		dif      = m_q - {1'b0, mb_q};
		prod     = sa_q * sb_q;
		q_bit    = rem_q >= {2'd0, sb_q};
		rem_sub  = q_bit ? (rem_q - {2'd0, sb_q}) : rem_q;
		bexp     = e_q + 12'sd127;
		dsh      = 12'sd1 - bexp;
		m_shift  = m_q[62:0] >> dsh[5:0];
		m_lost   = |(m_q[62:0] & ~({63{1'b1}} << dsh[5:0]));
		rq       = m_q[62:39];
		rbit     = m_q[38];
		sbit     = |m_q[37:0];
		rup      = rbit && (sbit || rq[0]);
		carry0   = (&rq) && rup;
		q1       = {1'b0, rq} + {24'd0, rup};
		bb       = bexp + {11'd0, q1[24]};
	end

	// Sequencer: next state and handshake.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = dec_done ? ST_DONE : ST_NORM;
			ST_NORM: begin
				if (sa_q[23] && sb_q[23]) begin
					unique case (cmd_q) inside
						CMD_MUL: state_d = ST_MUL;
						CMD_DIV: state_d = ST_DIV;
						default: state_d = ST_ALIGN;
					endcase
				end
			end
			ST_ALIGN: state_d = ST_ADD;
			ST_ADD: begin
				if (!esub_q) state_d = ST_DENORM;
				else if (dif == 64'd0) state_d = ST_DONE;
				else state_d = ST_LNORM;
			end
			ST_LNORM: if (m_q[62]) state_d = ST_DENORM;
			ST_MUL: state_d = ST_DENORM;
			ST_DIV: if (cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_DFIN;
			ST_DFIN: state_d = ST_DENORM;
			ST_DENORM: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					mem_we   = wr_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Register file storage and registered reads.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[rd_q] <= res_q;
		if (accept) begin
			rda_q <= mem_q[reg_sel(req.src1_index)];
			rdb_q <= mem_q[reg_sel(req.src2_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			sticky_q <= 5'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (mem_we) vld_q[rd_q] <= 1'b1;
			if (out_load) begin
				sticky_q <= sticky_q | fl_q;
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			rd_q  <= reg_sel(req.dest_index);
			ld_q  <= req.load_data;
			va_q  <= vld_q[reg_sel(req.src1_index)];
			vb_q  <= vld_q[reg_sel(req.src2_index)];
		end
		if (out_load) begin
			owv_q <= res_q;
			omv_q <= mv_q;
			ofl_q <= sticky_q | fl_q;
		end
		unique case (state_q)
			ST_FETCH: begin
				res_q  <= dec_res;
				mv_q   <= dec_mv;
				fl_q   <= dec_fl;
				wr_q   <= dec_wr;
				sa_q   <= ux_s;
				sb_q   <= uy_s;
				ea_q   <= ux_e;
				eb_q   <= uy_e;
				esub_q <= x_op[31] ^ y_op[31];
				sign_q <= (cmd_q == CMD_MUL || cmd_q == CMD_DIV) ?
					(a_op[31] ^ b_op[31]) : x_op[31];
			end
			ST_NORM: begin
				if (!sa_q[23]) begin
					sa_q <= {sa_q[22:0], 1'b0};
					ea_q <= ea_q - 12'sd1;
				end
				if (!sb_q[23]) begin
					sb_q <= {sb_q[22:0], 1'b0};
					eb_q <= eb_q - 12'sd1;
				end
				if (sa_q[23] && sb_q[23]) begin
					rem_q <= {2'd0, sa_q};
					qt_q  <= 26'd0;
					cnt_q <= 5'd0;
					e_q   <= ea_q - eb_q;
				end
			end
			ST_ALIGN: begin
				m_q <= {1'b0, sa_q, 39'd0};
				e_q <= ea_q;
				if (exp_gap >= 12'sd63) mb_q <= 63'd1;
				else mb_q <= mb_shift | {62'd0, mb_lost};
			end
			ST_ADD: begin
				if (!esub_q) begin
					if (sum[63]) begin
						m_q <= {1'b0, sum[63:1]} | {63'd0, sum[0]};
						e_q <= e_q + 12'sd1;
					end else begin
						m_q <= sum;
					end
				end else begin
					m_q   <= dif;
					res_q <= 32'd0;
				end
			end
			ST_LNORM: begin
				if (!m_q[62]) begin
					m_q <= {m_q[62:0], 1'b0};
					e_q <= e_q - 12'sd1;
				end
			end
			ST_MUL: begin
				if (prod[47]) begin
					m_q <= {1'b0, prod, 15'd0};
					e_q <= ea_q + eb_q + 12'sd1;
				end else begin
					m_q <= {1'b0, prod[46:0], 16'd0};
					e_q <= ea_q + eb_q;
				end
			end
			ST_DIV: begin
				qt_q  <= {qt_q[24:0], q_bit};
				rem_q <= {rem_sub[24:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_DFIN: begin
				// A nonzero partial remainder folds into the sticky bit.
				if (qt_q[25]) begin
					m_q <= {1'b0, qt_q, 36'd0, rem_q != 26'd0};
				end else begin
					m_q <= {1'b0, qt_q[24:0], 37'd0, rem_q != 26'd0};
					e_q <= e_q - 12'sd1;
				end
			end
			ST_DENORM: begin
				// Tiny results are shifted into subnormal range with the lost bits jammed.
				if (bexp < 12'sd1) begin
					sub_q  <= 1'b1;
					tiny_q <= !((bexp == 12'sd0) && carry0);
					if (dsh >= 12'sd63) m_q <= 64'd1;
					else m_q <= {1'b0, m_shift | {62'd0, m_lost}};
				end else begin
					sub_q <= 1'b0;
				end
			end
			ST_ROUND: begin
				if (sub_q) begin
					res_q <= {sign_q, 7'd0, q1[23:0]};
					if (rbit || sbit) fl_q <= fl_q | FL_NX | (tiny_q ? FL_UF : 5'd0);
				end else if (bb >= 12'sd255) begin
					res_q <= {sign_q, INF_BITS[30:0]};
					fl_q  <= fl_q | FL_OF | FL_NX;
				end else begin
					res_q <= {sign_q, bb[7:0], q1[24] ? q1[23:1] : q1[22:0]};
					if (rbit || sbit) fl_q <= fl_q | FL_NX;
				end
			end
			default: begin
			end
		endcase
	end

	`SPFU_ASSERT_NXT(a_accept_fetch, clk, arst_n, req.valid && req.ready, state_q == ST_FETCH, "accepted item did not enter fetch")
	`SPFU_ASSERT_IMP(a_div_bound, clk, arst_n, state_q == ST_DIV, cnt_q < 5'(DIV_STEPS), "divider step count overran")
	`SPFU_ASSERT_NXT(a_sticky_hold, clk, arst_n, 1'b1, (sticky_q & $past(sticky_q)) == $past(sticky_q), "sticky flag cleared")
	`SPFU_ASSERT_IMP(a_round_norm, clk, arst_n, state_q == ST_ROUND && !sub_q, m_q[62], "unnormalized significand at rounding")

endmodule

FILE: verif/tb.sv
// Testbench for the single-precision float unit.
//
// The sender plays a directed list of operand loads and special-value
// operations, then a long random mix of loads, arithmetic, moves and unused
// commands. A scoreboard keeps its own copy of the float register file and of
// the sticky exception flags. It predicts each result with integer
// arithmetic and compares every returned item against the oldest prediction.

module tb;

	import spfu_pkg::*;

	// Command codes that the package leaves unnamed and the block must ignore.
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS   = 1750;
	localparam int HOLDOFF_AT     = 1000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int CALM_FIRST     = 500;
	localparam int CALM_LAST      = 800;
	localparam int STALL_LIMIT    = 5000;
	localparam int DRAIN_CYCLES   = 60;

	typedef struct {
		logic [31:0] written_value;
		logic [31:0] move_value;
		logic [4:0]  accrued_flags;
	} fpu_result_t;

	// Rounds m right by sh bits, with ties going to the even neighbor.
	function automatic logic [63:0] round_right(input logic [63:0] m, input int sh,
		output logic lost);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		begin
			q = m >> sh;
			rem = m & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			lost = (rem != 64'd0);
			if (rem > half || (rem == half && q[0])) begin
				q = q + 64'd1;
			end
			return q;
		end
	endfunction

	// The value is m * 2^(e-62), with bit 62 of m set and a sticky bit in bit 0.
	function automatic logic [31:0] pack_rounded(input logic [31:0] sign, input int e,
		input logic [63:0] m, inout logic [4:0] fl);
		int biased;
		int sh;
		logic lost;
		logic unused_lost;
		logic tiny;
		logic [63:0] q;
		logic [63:0] q_wide;
		begin
			biased = e + 127;
			if (biased >= 1) begin
				q = round_right(m, 39, lost);
				if (q[24]) begin
					q = q >> 1;
					biased++;
				end
				if (biased >= 255) begin
					fl |= FL_OF | FL_NX;
					return sign | INF_BITS;
				end
				if (lost) begin
					fl |= FL_NX;
				end
				return sign | (32'(biased) << 23) | {9'd0, q[22:0]};
			end
			// Tininess is judged after rounding at unbounded exponent range.
			q_wide = round_right(m, 39, unused_lost);
			tiny = !(biased == 0 && q_wide[24]);
			sh = 40 - biased;
			if (sh > 63) begin
				q = 64'd0;
				lost = 1'b1;
			end else begin
				q = round_right(m, sh, lost);
			end
			if (lost) begin
				fl |= FL_NX | (tiny ? FL_UF : 5'd0);
			end
			return sign | q[31:0];
		end
	endfunction

	// Unbiased exponent and 24-bit significand of a finite nonzero value.
	function automatic void split_float(input logic [31:0] x, output int e,
		output logic [63:0] sig);
		begin
			sig = {41'd0, x[22:0]};
			if (x[30:23] == 8'd0) begin
				e = -126;
				while (!sig[23]) begin
					sig = sig << 1;
					e--;
				end
			end else begin
				e = int'(x[30:23]) - 127;
				sig[23] = 1'b1;
			end
		end
	endfunction

	function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b,
		inout logic [4:0] fl);
		logic [31:0] t;
		int ea;
		int eb;
		int d;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] m;
		begin
			if (is_nan(a) || is_nan(b)) begin
				if (is_snan(a) || is_snan(b)) begin
					fl |= FL_NV;
				end
				return CANON_NAN;
			end
			if (is_inf(a) || is_inf(b)) begin
				if (is_inf(a) && is_inf(b) && a[31] != b[31]) begin
					fl |= FL_NV;
					return CANON_NAN;
				end
				return is_inf(a) ? a : b;
			end
			if (is_zero(a) && is_zero(b)) begin
				return a & b & SIGN_BIT;
			end
			if (is_zero(a)) begin
				return b;
			end
			if (is_zero(b)) begin
				return a;
			end
			if (a[30:0] < b[30:0]) begin
				t = a;
				a = b;
				b = t;
			end
			split_float(a, ea, ma);
			split_float(b, eb, mb);
			ma = ma << 39;
			mb = mb << 39;
			d = ea - eb;
			if (d >= 63) begin
				mb = 64'd1;
			end else if (d > 0) begin
				mb = (mb >> d) | 64'((mb & ((64'd1 << d) - 64'd1)) != 64'd0);
			end
			if (a[31] == b[31]) begin
				m = ma + mb;
				if (m[63]) begin
					m = (m >> 1) | {63'd0, m[0]};
					ea++;
				end
			end else begin
				m = ma - mb;
				if (m == 64'd0) begin
					return 32'd0;
				end
				while (!m[62]) begin
					m = m << 1;
					ea--;
				end
			end
			return pack_rounded(a & SIGN_BIT, ea, m, fl);
		end
	endfunction

	function automatic logic [31:0] float_product(input logic [31:0] a, input logic [31:0] b,
		inout logic [4:0] fl);
		logic [31:0] s;
		int ea;
		int eb;
		int e;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] p;
		begin
			s = (a ^ b) & SIGN_BIT;
			if (is_nan(a) || is_nan(b)) begin
				if (is_snan(a) || is_snan(b)) begin
					fl |= FL_NV;
				end
				return CANON_NAN;
			end
			if (is_inf(a) || is_inf(b)) begin
				if (is_zero(a) || is_zero(b)) begin
					fl |= FL_NV;
					return CANON_NAN;
				end
				return s | INF_BITS;
			end
			if (is_zero(a) || is_zero(b)) begin
				return s;
			end
			split_float(a, ea, ma);
			split_float(b, eb, mb);
			e = ea + eb;
			p = ma * mb;
			if (p[47]) begin
				e++;
				p = p << 15;
			end else begin
				p = p << 16;
			end
			return pack_rounded(s, e, p, fl);
		end
	endfunction

	function automatic logic [31:0] float_quotient(input logic [31:0] a, input logic [31:0] b,
		inout logic [4:0] fl);
		logic [31:0] s;
		int ea;
		int eb;
		int e;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] q;
		logic [63:0] r;
		begin
			s = (a ^ b) & SIGN_BIT;
			if (is_nan(a) || is_nan(b)) begin
				if (is_snan(a) || is_snan(b)) begin
					fl |= FL_NV;
				end
				return CANON_NAN;
			end
			if (is_inf(a)) begin
				if (is_inf(b)) begin
					fl |= FL_NV;
					return CANON_NAN;
				end
				return s | INF_BITS;
			end
			if (is_inf(b)) begin
				return s;
			end
			if (is_zero(b)) begin
				if (is_zero(a)) begin
					fl |= FL_NV;
					return CANON_NAN;
				end
				fl |= FL_DZ;
				return s | INF_BITS;
			end
			if (is_zero(a)) begin
				return s;
			end
			split_float(a, ea, ma);
			split_float(b, eb, mb);
			e = ea - eb;
			q = (ma << 40) / mb;
			r = (ma << 40) % mb;
			if (q[40]) begin
				q = q << 22;
			end else begin
				q = q << 23;
				e--;
			end
			q[0] = q[0] | (r != 64'd0);
			return pack_rounded(s, e, q, fl);
		end
	endfunction

	// Mirrors the register file and sticky flags and queues predicted results.
	class fpu_scoreboard;
		logic [31:0] fregs [SPFU_NUM_FREGS];
		logic [4:0]  sticky;
		fpu_result_t pending [$];
		int          fails;

		function new();
			foreach (fregs[i]) begin
				fregs[i] = 32'd0;
			end
			sticky = 5'd0;
			fails = 0;
		endfunction

		function void note_item(input logic [2:0] cmd, input logic [4:0] rd,
			input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] data);
			logic [31:0] a;
			logic [31:0] b;
			logic [4:0]  fl;
			fpu_result_t res;
			begin
				a = fregs[rs1 % SPFU_NUM_FREGS];
				b = fregs[rs2 % SPFU_NUM_FREGS];
				fl = 5'd0;
				res.written_value = 32'd0;
				res.move_value = 32'd0;
				case (cmd)
					CMD_ADD: res.written_value = float_sum(a, b, fl);
					CMD_SUB: res.written_value = float_sum(a, b ^ SIGN_BIT, fl);
					CMD_MUL: res.written_value = float_product(a, b, fl);
					CMD_DIV: res.written_value = float_quotient(a, b, fl);
					CMD_LOAD: res.written_value = data;
					CMD_MOVE: res.move_value = a;
					default: ;
				endcase
				if (cmd <= CMD_LOAD) begin
					fregs[rd % SPFU_NUM_FREGS] = res.written_value;
				end
				sticky = sticky | fl;
				res.accrued_flags = sticky;
				pending.push_back(res);
			end
		endfunction

		function void check_result(input logic [31:0] wv, input logic [31:0] mv,
			input logic [4:0] fl);
			fpu_result_t want;
			begin
				if (pending.size() == 0) begin
					$display("%0t: result with none expected: written %h move %h flags %h",
						$time, wv, mv, fl);
					fails++;
					return;
				end
				want = pending.pop_front();
				if (wv !== want.written_value) begin
					$display("%0t: written_value expected %h actual %h", $time,
						want.written_value, wv);
					fails++;
				end
				if (mv !== want.move_value) begin
					$display("%0t: move_value expected %h actual %h", $time,
						want.move_value, mv);
					fails++;
				end
				if (fl !== want.accrued_flags) begin
					$display("%0t: accrued_flags expected %h actual %h", $time,
						want.accrued_flags, fl);
					fails++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spfu_req_if req ();
	spfu_rsp_if rsp ();

	single_precision_float_unit_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	fpu_scoreboard board;
	int accepted_items;
	int idle_cycles;

	// Free-running clock with a period of 20.
	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Inside the calm window neither side idles, so the block runs back to back.
	function automatic logic calm_window();
		return accepted_items >= CALM_FIRST && accepted_items < CALM_LAST;
	endfunction

	// Operand patterns lean toward the corners: specials, subnormals, values
	// near overflow, and ordinary magnitudes that keep sums from cancelling fully.
	function automatic logic [31:0] pick_float();
		logic [31:0] specials [10];
		logic [31:0] x;
		begin
			specials = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
				32'h7fc0_0000, 32'h7f80_0001, 32'hffbf_ffff, 32'h0000_0001,
				32'h7f7f_ffff, 32'h0080_0000};
			x = $urandom;
			case ($urandom_range(9))
				0: x = specials[$urandom_range(9)];
				1, 2: x[30:23] = 8'($urandom_range(3));
				3: x[30:23] = 8'($urandom_range(254, 250));
				4: ;
				default: x[30:23] = 8'($urandom_range(154, 100));
			endcase
			return x;
		end
	endfunction

	// Offers one item and holds it until the block takes it. The valid line is
	// only lowered when a gap is inserted, so it never toggles within a step.
	task automatic send_item(input logic [2:0] cmd, input logic [4:0] rd,
		input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] data);
		begin
			if (!calm_window() && $urandom_range(99) < 26) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(4, 1)) @(posedge clk);
			end
			req.valid <= 1'b1;
			req.command <= cmd;
			req.dest_index <= rd;
			req.src1_index <= rs1;
			req.src2_index <= rs2;
			req.load_data <= data;
			@(posedge clk);
			while (!req.ready) begin
				@(posedge clk);
			end
		end
	endtask

	task automatic load_reg(input logic [4:0] rd, input logic [31:0] data);
		send_item(CMD_LOAD, rd, 5'($urandom), 5'($urandom), data);
	endtask

	task automatic run_op(input logic [2:0] cmd, input logic [4:0] rd,
		input logic [4:0] rs1, input logic [4:0] rs2);
		send_item(cmd, rd, rs1, rs2, $urandom);
	endtask

	// Both channels are sampled at the clock edge, before any update made on it.
	// A result is checked before the item of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				board.check_result(rsp.written_value, rsp.move_value, rsp.accrued_flags);
			end
			if (req.valid && req.ready) begin
				board.note_item(req.command, req.dest_index, req.src1_index,
					req.src2_index, req.load_data);
				accepted_items++;
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result side: random back-pressure, none in the calm window, and one long
	// hold-off once enough items have gone in so that the block fills and stalls.
	initial begin : result_side
		logic held;
		held = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_items >= HOLDOFF_AT) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			rsp.ready <= calm_window() || ($urandom_range(99) >= 26);
		end
	end

	initial begin : stimulus
		int pick;
		board = new();
		accepted_items = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.command <= CMD_ADD;
		req.dest_index <= 5'd0;
		req.src1_index <= 5'd0;
		req.src2_index <= 5'd0;
		req.load_data <= 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operands for the directed cases; register zero keeps its reset value.
		load_reg(5'd1, 32'h3f80_0000);
		load_reg(5'd3, 32'h7f80_0000);
		load_reg(5'd4, 32'hff80_0000);
		load_reg(5'd5, 32'h7fc0_0001);
		load_reg(5'd6, 32'h7f80_0001);
		load_reg(5'd7, 32'h0000_0001);
		load_reg(5'd8, 32'h7f7f_ffff);
		load_reg(5'd9, 32'h8000_0000);
		load_reg(5'd10, 32'h3f00_0000);
		// A NaN written by a load is kept as given.
		load_reg(5'd11, 32'hffff_ffff);

		// Infinity minus infinity, zero times infinity, zero over zero and
		// infinity over infinity are all invalid.
		run_op(CMD_ADD, 5'd12, 5'd3, 5'd4);
		run_op(CMD_MUL, 5'd12, 5'd0, 5'd3);
		run_op(CMD_DIV, 5'd12, 5'd0, 5'd0);
		run_op(CMD_DIV, 5'd12, 5'd3, 5'd3);
		// Finite over zero, then signaling and quiet NaN operands.
		run_op(CMD_DIV, 5'd12, 5'd1, 5'd0);
		run_op(CMD_ADD, 5'd12, 5'd6, 5'd1);
		run_op(CMD_SUB, 5'd12, 5'd5, 5'd1);
		// Overflow from the largest finite value, underflow from the smallest.
		run_op(CMD_MUL, 5'd12, 5'd8, 5'd8);
		run_op(CMD_MUL, 5'd12, 5'd7, 5'd10);
		// Exact cancellation and the signs of zero sums.
		run_op(CMD_SUB, 5'd12, 5'd1, 5'd1);
		run_op(CMD_ADD, 5'd12, 5'd9, 5'd9);
		run_op(CMD_ADD, 5'd12, 5'd0, 5'd9);
		run_op(CMD_MOVE, 5'd12, 5'd11, 5'd0);
		run_op(CMD_SPARE_LO, 5'd13, 5'd1, 5'd1);
		run_op(CMD_SPARE_HI, 5'd14, 5'd1, 5'd1);
		load_reg(5'd31, 32'h0000_0000);
		run_op(CMD_MOVE, 5'd0, 5'd31, 5'd31);

		// Random part: loads keep the operands interesting, arithmetic dominates.
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 18) begin
				load_reg(5'($urandom), ($urandom_range(3) == 0) ? $urandom : pick_float());
			end else if (pick < 80) begin
				run_op(3'($urandom_range(3)), 5'($urandom), 5'($urandom), 5'($urandom));
			end else if (pick < 92) begin
				run_op(CMD_MOVE, 5'($urandom), 5'($urandom), 5'($urandom));
			end else begin
				run_op(($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI,
					5'($urandom), 5'($urandom), 5'($urandom));
			end
		end
		req.valid <= 1'b0;

		// The wait lets the monitor record the last accepted item before the queue is checked.
		@(posedge clk);
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0 && board.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
